/* hdl/window_blur_and_sobel_edge_top_assert.svh */
// assertion macros shared by the checker of the window blur and sobel edge block
`ifndef WINDOW_BLUR_AND_SOBEL_EDGE_TOP_ASSERT_SVH
`define WINDOW_BLUR_AND_SOBEL_EDGE_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define WBSE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define WBSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/wbse_pkg.sv */
// shared types and constants of the window blur and sobel edge block
`timescale 1ns / 1ps

package wbse_pkg;

    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 512;
    localparam int MIN_SIZE       = 3;

    localparam int PIX_W = 12;
    localparam int CH_W  = 4;
    localparam int CFG_W = 10;
    localparam int THR_W = 7;
    localparam int IDX_W = 2;
    localparam int SUM_W = 8;
    localparam int MAG_W = 7;

    localparam logic [IDX_W-1:0] REG_FILTER_MODE    = 2'd0;
    localparam logic [IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd1;
    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH    = 2'd2;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd3;

    localparam logic MODE_BLUR = 1'b0;
    localparam logic MODE_EDGE = 1'b1;

    localparam logic             RST_FILTER_MODE    = MODE_EDGE;
    localparam logic [THR_W-1:0] RST_EDGE_THRESHOLD = 7'd18;
    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH    = 10'd320;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT   = 10'd240;

    // 16-bit fixed point luma weights, they add up to 65536
    localparam int GREY_R = 19595;
    localparam int GREY_G = 38470;
    localparam int GREY_B = 7471;

    // x/9 as (x*57)>>9, exact for x up to 135
    localparam int DIV9_MUL = 57;

    localparam logic [PIX_W-1:0] WHITE = 12'hfff;
    localparam logic [PIX_W-1:0] BLACK = 12'h000;

    typedef struct packed {
        logic             filter_mode;
        logic [THR_W-1:0] edge_threshold;
        logic [CFG_W-1:0] frame_width;
        logic [CFG_W-1:0] frame_height;
    } cfg_t;

    typedef struct packed {
        logic             valid;
        logic             emit;
        logic             last;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] pix;
    } line_item_t;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic [SUM_W-1:0] sum_r;
        logic [SUM_W-1:0] sum_g;
        logic [SUM_W-1:0] sum_b;
        logic [MAG_W-1:0] mag;
    } filt_item_t;

endpackage

/* hdl/wbse_stream_if.sv */
// pixel request channels of the window blur and sobel edge block
`timescale 1ns / 1ps

interface wbse_pix_in_if;
    logic                      valid;
    logic                      ready;
    logic [wbse_pkg::PIX_W-1:0] pixel_in;
    logic                      frame_start;

    modport source (output valid, output pixel_in, output frame_start, input ready);
    modport sink (input valid, input pixel_in, input frame_start, output ready);
endinterface

interface wbse_pix_out_if;
    logic                      valid;
    logic                      ready;
    logic [wbse_pkg::PIX_W-1:0] pixel_out;
    logic                      out_last;

    modport source (output valid, output pixel_out, output out_last, input ready);
    modport sink (input valid, input pixel_out, input out_last, output ready);
endinterface

/* hdl/window_blur_and_sobel_edge_top.sv */
// top level of the 3x3 box blur and sobel edge filter on an rgb444 pixel stream
`timescale 1ns / 1ps
// a pixel moves through the stage 1, window, sum and output registers to its result
// throughput: one pixel per unstalled cycle; line store: one read and one write a cycle
// ready drops only after two results are held and the output is stalled
// reset: config to mode edge, threshold 18, 320x240; counters, window and valids cleared
// the line store is not cleared; it is always written before an interior pixel reads it

module window_blur_and_sobel_edge_top #(
    parameter int MAX_WIDTH  = wbse_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = wbse_pkg::MAX_HEIGHT_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [wbse_pkg::IDX_W-1:0] cfg_index,
    input  logic [wbse_pkg::CFG_W-1:0] cfg_data,
    wbse_pix_in_if.sink                pix_in,
    wbse_pix_out_if.source             pix_out
);

    // configuration registers
    wbse_pkg::cfg_t       cfg_reg;
    // pipeline control
    logic                 adv;
    logic                 in_take;
    // stage handoffs
    wbse_pkg::line_item_t s1_item;
    wbse_pkg::filt_item_t s3_item;

    // register writes; the user does them only while the block is idle, not enforced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_mode    <= wbse_pkg::RST_FILTER_MODE;
            cfg_reg.edge_threshold <= wbse_pkg::RST_EDGE_THRESHOLD;
            cfg_reg.frame_width    <= wbse_pkg::RST_FRAME_WIDTH;
            cfg_reg.frame_height   <= wbse_pkg::RST_FRAME_HEIGHT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wbse_pkg::REG_FILTER_MODE:    cfg_reg.filter_mode    <= cfg_data[0];
                wbse_pkg::REG_EDGE_THRESHOLD: cfg_reg.edge_threshold <= cfg_data[wbse_pkg::THR_W-1:0];
                wbse_pkg::REG_FRAME_WIDTH:    cfg_reg.frame_width    <= cfg_data;
                wbse_pkg::REG_FRAME_HEIGHT:   cfg_reg.frame_height   <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // a request is taken whenever the whole pipeline can move
    assign pix_in.ready = adv;
    assign in_take      = pix_in.valid && adv;

    // stage 1: position counters, line store read and write-back of the shifted rows
    wbse_line_buf #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_line_buf (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .adv            (adv),
        .in_take        (in_take),
        .in_pixel       (pix_in.pixel_in),
        .in_frame_start (pix_in.frame_start),
        .s1_item        (s1_item)
    );

    // stages 2 and 3: window shift with grey values, then sums and gradient magnitude
    wbse_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .s1_item (s1_item),
        .s3_item (s3_item)
    );

    // final stage: divide or threshold, output register and skid entry
    wbse_filter_out u_filter_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .s3_item (s3_item),
        .adv     (adv),
        .pix_out (pix_out)
    );

endmodule

/* hdl/wbse_line_buf.sv */
// position counters and two-row line store with read-modify-write forwarding
`timescale 1ns / 1ps

module wbse_line_buf #(
    parameter int MAX_WIDTH  = wbse_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = wbse_pkg::MAX_HEIGHT_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  wbse_pkg::cfg_t             cfg,
    input  logic                       adv,
    input  logic                       in_take,
    input  logic [wbse_pkg::PIX_W-1:0] in_pixel,
    input  logic                       in_frame_start,
    output wbse_pkg::line_item_t       s1_item
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int WSZ  = $clog2(MAX_WIDTH + 1);
    localparam int HSZ  = $clog2(MAX_HEIGHT + 1);
    localparam int SZA  = (WSZ > HSZ) ? WSZ : HSZ;
    localparam int SZW  = ((SZA > wbse_pkg::CFG_W) ? SZA : wbse_pkg::CFG_W) + 1;
    localparam int LW   = 2 * wbse_pkg::PIX_W;

    logic [CW-1:0]  col_reg;
    logic [RW-1:0]  row_reg;
    logic [CW-1:0]  cur_col;
    logic [RW-1:0]  cur_row;
    logic [CW-1:0]  col_next;
    logic [RW-1:0]  row_next;
    logic [SZW-1:0] w_eff;
    logic [SZW-1:0] h_eff;
    logic [SZW-1:0] c_ext;
    logic [SZW-1:0] r_ext;
    logic           emit;
    logic           last;

    logic [LW-1:0]              mem [MAX_WIDTH];
    logic [LW-1:0]              rd_data_reg;
    logic [LW-1:0]              fwd_data_reg;
    logic                       fwd_hit_reg;
    logic                       s1_valid_reg;
    logic                       s1_emit_reg;
    logic                       s1_last_reg;
    logic [wbse_pkg::PIX_W-1:0] s1_pix_reg;
    logic [CW-1:0]              s1_addr_reg;
    logic [LW-1:0]              lines;
    logic [LW-1:0]              wr_data;

    // frame size held to 3..max
    always_comb
    begin
        if (SZW'(cfg.frame_width) < SZW'(wbse_pkg::MIN_SIZE))
        begin
            w_eff = SZW'(wbse_pkg::MIN_SIZE);
        end
        else if (SZW'(cfg.frame_width) > SZW'(MAX_WIDTH))
        begin
            w_eff = SZW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = SZW'(cfg.frame_width);
        end
        if (SZW'(cfg.frame_height) < SZW'(wbse_pkg::MIN_SIZE))
        begin
            h_eff = SZW'(wbse_pkg::MIN_SIZE);
        end
        else if (SZW'(cfg.frame_height) > SZW'(MAX_HEIGHT))
        begin
            h_eff = SZW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = SZW'(cfg.frame_height);
        end
    end

    always_comb
    begin
        cur_col = in_frame_start ? '0 : col_reg;
        cur_row = in_frame_start ? '0 : row_reg;
        c_ext   = SZW'(cur_col);
        r_ext   = SZW'(cur_row);
        emit    = (r_ext >= SZW'(2)) && (c_ext >= SZW'(2)) && (r_ext < h_eff) && (c_ext < w_eff);
        last    = (r_ext == h_eff - SZW'(1)) && (c_ext == w_eff - SZW'(1));
        if (c_ext + SZW'(1) >= w_eff)
        begin
            col_next = '0;
            row_next = (r_ext + SZW'(1) >= h_eff) ? '0 : cur_row + 1'b1;
        end
        else
        begin
            col_next = cur_col + 1'b1;
            row_next = cur_row;
        end
    end

    // a write in the same cycle as a read of that entry is forwarded to it
    assign lines   = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign wr_data = {lines[wbse_pkg::PIX_W-1:0], s1_pix_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (s1_valid_reg)
            begin
                mem[s1_addr_reg] <= wr_data;
            end
            if (in_take)
            begin
                rd_data_reg <= mem[cur_col];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_pix_reg   <= in_pixel;
            s1_addr_reg  <= cur_col;
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
            s1_last_reg  <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                s1_valid_reg <= in_take;
            end
            if (in_take)
            begin
                col_reg     <= col_next;
                row_reg     <= row_next;
                s1_emit_reg <= emit;
                s1_last_reg <= last;
                fwd_hit_reg <= s1_valid_reg && (s1_addr_reg == cur_col);
            end
        end
    end

    assign s1_item.valid = s1_valid_reg;
    assign s1_item.emit  = s1_emit_reg;
    assign s1_item.last  = s1_last_reg;
    assign s1_item.top   = lines[LW-1:wbse_pkg::PIX_W];
    assign s1_item.mid   = lines[wbse_pkg::PIX_W-1:0];
    assign s1_item.pix   = s1_pix_reg;

endmodule

/* hdl/wbse_window.sv */
// 3x3 window with grey values, channel sums and sobel magnitude stage
`timescale 1ns / 1ps

module wbse_window (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  wbse_pkg::line_item_t s1_item,
    output wbse_pkg::filt_item_t s3_item
);

    logic [wbse_pkg::PIX_W-1:0] pix_win_reg  [9];
    logic [wbse_pkg::CH_W-1:0]  grey_win_reg [9];
    logic                       s2_valid_reg;
    logic                       s2_last_reg;
    logic signed [6:0]          q [9];
    logic signed [6:0]          gx;
    logic signed [6:0]          gy;
    logic signed [6:0]          gx_abs;
    logic signed [6:0]          gy_abs;
    logic [wbse_pkg::SUM_W-1:0] sum_r;
    logic [wbse_pkg::SUM_W-1:0] sum_g;
    logic [wbse_pkg::SUM_W-1:0] sum_b;
    logic [wbse_pkg::MAG_W-1:0] mag;
    wbse_pkg::filt_item_t       s3_reg;

    function automatic logic [wbse_pkg::CH_W-1:0] grey_of(input logic [wbse_pkg::PIX_W-1:0] p);
        logic [19:0] acc;
        acc = 20'(wbse_pkg::GREY_R) * 20'(p[11:8]) + 20'(wbse_pkg::GREY_G) * 20'(p[7:4])
            + 20'(wbse_pkg::GREY_B) * 20'(p[3:0]);
        return acc[19:16];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                pix_win_reg[i]  <= '0;
                grey_win_reg[i] <= '0;
            end
            s2_valid_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
        end
        else if (adv)
        begin
            if (s1_item.valid)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    pix_win_reg[3*k]      <= pix_win_reg[3*k+1];
                    pix_win_reg[3*k+1]    <= pix_win_reg[3*k+2];
                    grey_win_reg[3*k]     <= grey_win_reg[3*k+1];
                    grey_win_reg[3*k+1]   <= grey_win_reg[3*k+2];
                end
                pix_win_reg[2]  <= s1_item.top;
                pix_win_reg[5]  <= s1_item.mid;
                pix_win_reg[8]  <= s1_item.pix;
                grey_win_reg[2] <= grey_of(s1_item.top);
                grey_win_reg[5] <= grey_of(s1_item.mid);
                grey_win_reg[8] <= grey_of(s1_item.pix);
            end
            s2_valid_reg <= s1_item.valid && s1_item.emit;
            s2_last_reg  <= s1_item.last;
        end
    end

    always_comb
    begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int i = 0; i < 9; i++)
        begin
            sum_r = sum_r + wbse_pkg::SUM_W'(pix_win_reg[i][11:8]);
            sum_g = sum_g + wbse_pkg::SUM_W'(pix_win_reg[i][7:4]);
            sum_b = sum_b + wbse_pkg::SUM_W'(pix_win_reg[i][3:0]);
            q[i]  = $signed({3'b000, grey_win_reg[i]});
        end
        gx     = (q[0] - q[2]) + ((q[3] - q[5]) <<< 1) + (q[6] - q[8]);
        gy     = (q[0] + (q[1] <<< 1) + q[2]) - (q[6] + (q[7] <<< 1) + q[8]);
        gx_abs = gx[6] ? -gx : gx;
        gy_abs = gy[6] ? -gy : gy;
        mag    = {1'b0, gx_abs[5:0]} + {1'b0, gy_abs[5:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_reg <= '0;
        end
        else if (adv)
        begin
            s3_reg.valid <= s2_valid_reg;
            s3_reg.last  <= s2_last_reg;
            s3_reg.sum_r <= sum_r;
            s3_reg.sum_g <= sum_g;
            s3_reg.sum_b <= sum_b;
            s3_reg.mag   <= mag;
        end
    end

    assign s3_item = s3_reg;

endmodule

/* hdl/wbse_filter_out.sv */
// blur divide or edge threshold, then output register with skid entry
`timescale 1ns / 1ps

module wbse_filter_out (
    input  logic                 clk,
    input  logic                 rst_n,
    input  wbse_pkg::cfg_t       cfg,
    input  wbse_pkg::filt_item_t s3_item,
    output logic                 adv,
    wbse_pix_out_if.source       pix_out
);

    logic [wbse_pkg::PIX_W-1:0] res;
    logic                       produce;
    logic                       out_valid_reg;
    logic [wbse_pkg::PIX_W-1:0] out_pix_reg;
    logic                       out_last_reg;
    logic                       skid_valid_reg;
    logic [wbse_pkg::PIX_W-1:0] skid_pix_reg;
    logic                       skid_last_reg;

    function automatic logic [wbse_pkg::CH_W-1:0] div9(input logic [wbse_pkg::SUM_W-1:0] s);
        logic [13:0] prod;
        prod = 14'(s) * 14'(wbse_pkg::DIV9_MUL);
        return prod[12:9];
    endfunction

    always_comb
    begin
        if (cfg.filter_mode == wbse_pkg::MODE_EDGE)
        begin
            res = (s3_item.mag < cfg.edge_threshold) ? wbse_pkg::BLACK : wbse_pkg::WHITE;
        end
        else
        begin
            res = {div9(s3_item.sum_r), div9(s3_item.sum_g), div9(s3_item.sum_b)};
        end
    end

    // pipeline moves whenever the skid entry is free
    assign adv     = !skid_valid_reg;
    assign produce = adv && s3_item.valid;

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg)
        begin
            if (produce && (!out_valid_reg || pix_out.ready))
            begin
                out_pix_reg  <= res;
                out_last_reg <= s3_item.last;
            end
            else if (produce)
            begin
                skid_pix_reg  <= res;
                skid_last_reg <= s3_item.last;
            end
        end
        else if (pix_out.ready)
        begin
            out_pix_reg  <= skid_pix_reg;
            out_last_reg <= skid_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!skid_valid_reg)
        begin
            if (produce && (!out_valid_reg || pix_out.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (produce)
            begin
                skid_valid_reg <= 1'b1;
            end
            else if (pix_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
        else if (pix_out.ready)
        begin
            skid_valid_reg <= 1'b0;
        end
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.pixel_out = out_pix_reg;
    assign pix_out.out_last  = out_last_reg;

endmodule

/* hdl/wbse_port_checker.sv */
// port-level checks of the window blur and sobel edge block and their bind
`timescale 1ns / 1ps
`include "window_blur_and_sobel_edge_top_assert.svh"

module wbse_port_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [wbse_pkg::PIX_W-1:0] pixel_out,
    input logic                       out_last
);

    `WBSE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pixel_out) && $stable(out_last), "stalled result changed")
    `WBSE_ASSERT_NOW(a_stall_has_result, !in_ready, out_valid, "input stalled with no result waiting")
    `WBSE_ASSERT_NEXT(a_take_frees_input, out_ready, in_ready, "input still stalled after a result was taken")
    `WBSE_ASSERT_NOW(a_stall_cause, $fell(in_ready), $past(out_valid && !out_ready), "input stalled without output backpressure")

endmodule

bind window_blur_and_sobel_edge_top wbse_port_checker u_port_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (pix_in.ready),
    .out_valid (pix_out.valid),
    .out_ready (pix_out.ready),
    .pixel_out (pix_out.pixel_out),
    .out_last  (pix_out.out_last)
);

/* verif/tb_window_blur_and_sobel_edge_top.sv */
// self-checking testbench of the window blur and sobel edge top level
`timescale 1ns / 1ps

// pixel requests go in through the input channel, one per handshake; a line buffer
// model in this file follows every accepted pixel and queues the filtered pixel it
// yields, and a checker compares each result request against the oldest queued one.
// both channels idle and stall at random, with stretches of no idling at all.
// the configuration is only rewritten once the block has drained.

module tb_window_blur_and_sobel_edge_top;

    localparam int FRAME_MAX      = wbse_pkg::MAX_WIDTH_DEF;  // columns held per line row
    localparam int DRAIN_CYCLES   = 8;              // margin to let the pipeline empty
    localparam int WATCHDOG_LIMIT = 2000;           // cycles with no request moving
    localparam int RANDOM_ITEMS   = 720;
    localparam int REPORT_LIMIT   = 10;

    // kinds of frame content
    typedef enum int
    {
        TEXTURE_RANDOM,
        TEXTURE_TWO_TONE,
        TEXTURE_GREY,
        TEXTURE_SOFT
    } texture_t;

    typedef struct packed {
        logic [wbse_pkg::PIX_W-1:0] pixel;
        logic                       last;
    } filtered_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [wbse_pkg::IDX_W-1:0] cfg_index;
    logic [wbse_pkg::CFG_W-1:0] cfg_data;

    wbse_pix_in_if  pix_in_ch ();
    wbse_pix_out_if pix_out_ch ();

    window_blur_and_sobel_edge_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_in    (pix_in_ch),
        .pix_out   (pix_out_ch)
    );

    // configuration as the block holds it
    logic                       mode_q;
    logic [wbse_pkg::THR_W-1:0] threshold_q;
    logic [wbse_pkg::CFG_W-1:0] width_q;
    logic [wbse_pkg::CFG_W-1:0] height_q;

    // line buffers: entries 0.. hold row r-2, entries FRAME_MAX.. hold row r-1
    logic [wbse_pkg::PIX_W-1:0] line_mem [0:2*FRAME_MAX-1];
    // 3x3 window, row-major, right column newest
    logic [wbse_pkg::PIX_W-1:0] win [0:8];
    int                         row_pos;
    int                         col_pos;

    filtered_t expected_pixels[$];
    int        error_count;
    bit        no_idle;     // set for stretches with no gaps and no stalls

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // line buffer filter model
    // ------------------------------------------------------------------
    function automatic int clamp_size(input logic [wbse_pkg::CFG_W-1:0] value, input int hi);
        if (value < wbse_pkg::MIN_SIZE)
            return wbse_pkg::MIN_SIZE;
        if (value > hi)
            return hi;
        return int'(value);
    endfunction

    // 4-bit luma, 16-bit fixed point weights, truncated
    function automatic int grey_level(input logic [wbse_pkg::PIX_W-1:0] p);
        return int'((wbse_pkg::GREY_R * p[11:8] + wbse_pkg::GREY_G * p[7:4]
                     + wbse_pkg::GREY_B * p[3:0]) >> 16);
    endfunction

    // takes one pixel, returns 1 and the filtered pixel when an interior pixel comes out
    function automatic bit filter_pixel(input logic [wbse_pkg::PIX_W-1:0] pix,
                                        input logic start, output filtered_t res);
        int                         w;
        int                         h;
        int                         r;
        int                         c;
        int                         col;
        int                         gx;
        int                         gy;
        int                         sr;
        int                         sg;
        int                         sb;
        int                         q [0:8];
        logic [wbse_pkg::PIX_W-1:0] top;
        logic [wbse_pkg::PIX_W-1:0] mid;

        w = clamp_size(width_q, wbse_pkg::MAX_WIDTH_DEF);
        h = clamp_size(height_q, wbse_pkg::MAX_HEIGHT_DEF);
        if (start)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        r   = row_pos;
        c   = col_pos;
        col = c % FRAME_MAX;

        // rotate the column through both line buffers
        top                      = line_mem[col];
        mid                      = line_mem[FRAME_MAX + col];
        line_mem[col]            = mid;
        line_mem[FRAME_MAX + col] = pix;

        for (int k = 0; k < 3; k++)
        begin
            win[3*k]   = win[3*k+1];
            win[3*k+1] = win[3*k+2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = pix;

        res          = '0;
        filter_pixel = 1'b0;
        if (r >= 2 && c >= 2 && r < h && c < w)
        begin
            if (mode_q == wbse_pkg::MODE_EDGE)
            begin
                for (int i = 0; i < 9; i++)
                    q[i] = grey_level(win[i]);
                gx = (q[0] - q[2]) + 2 * (q[3] - q[5]) + (q[6] - q[8]);
                gy = (q[0] + 2 * q[1] + q[2]) - (q[6] + 2 * q[7] + q[8]);
                if (gx < 0)
                    gx = -gx;
                if (gy < 0)
                    gy = -gy;
                res.pixel = (gx + gy < int'(threshold_q)) ? wbse_pkg::BLACK : wbse_pkg::WHITE;
            end
            else
            begin
                sr = 0;
                sg = 0;
                sb = 0;
                for (int i = 0; i < 9; i++)
                begin
                    sr += win[i][11:8];
                    sg += win[i][7:4];
                    sb += win[i][3:0];
                end
                res.pixel = {wbse_pkg::CH_W'(sr / 9), wbse_pkg::CH_W'(sg / 9),
                             wbse_pkg::CH_W'(sb / 9)};
            end
            res.last     = (r == h - 1 && c == w - 1);
            filter_pixel = 1'b1;
        end

        // raster position, wrapping on its own at the end of a row and a frame
        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
            col_pos = c + 1;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int roll;

        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [wbse_pkg::PIX_W-1:0] frame_pixel(input texture_t tex);
        logic [wbse_pkg::CH_W-1:0] lvl;

        case (tex)
            TEXTURE_RANDOM:
                return wbse_pkg::PIX_W'($urandom_range(0, 4095));
            TEXTURE_TWO_TONE:
                return $urandom_range(0, 1) ? wbse_pkg::WHITE : wbse_pkg::BLACK;
            TEXTURE_GREY:
            begin
                lvl = wbse_pkg::CH_W'($urandom_range(0, 15));
                return {lvl, lvl, lvl};
            end
            default:
            begin
                // low contrast, gradients land near small thresholds
                lvl = wbse_pkg::CH_W'($urandom_range(6, 9));
                return {lvl, wbse_pkg::CH_W'($urandom_range(6, 9)), lvl};
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%t mismatch: %s", $time, what);
    endtask

    // register write, only issued while the block is idle
    task automatic write_reg(input logic [wbse_pkg::IDX_W-1:0] idx,
                             input logic [wbse_pkg::CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            wbse_pkg::REG_FILTER_MODE:    mode_q      = value[0];
            wbse_pkg::REG_EDGE_THRESHOLD: threshold_q = value[wbse_pkg::THR_W-1:0];
            wbse_pkg::REG_FRAME_WIDTH:    width_q     = value;
            wbse_pkg::REG_FRAME_HEIGHT:   height_q    = value;
            default: ;
        endcase
    endtask

    // one pixel request; returns at the edge that takes it
    task automatic send_pixel(input logic [wbse_pkg::PIX_W-1:0] pix, input logic start);
        int        gap;
        filtered_t res;

        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            pix_in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_in_ch.valid       = 1'b1;
        pix_in_ch.pixel_in    = pix;
        pix_in_ch.frame_start = start;
        @(posedge clk);
        while (!pix_in_ch.ready)
            @(posedge clk);
        if (filter_pixel(pix, start, res))
            expected_pixels.push_back(res);
    endtask

    task automatic send_frame(input int w, input int h, input texture_t tex,
                              input bit with_start);
        for (int n = 0; n < w * h; n++)
            send_pixel(frame_pixel(tex), with_start && n == 0);
    endtask

    // stop sending, let every result come out, then cover pixels that give none
    task automatic drain_pipeline();
        @(negedge clk);
        pix_in_ch.valid = 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // mode and threshold stay at their reset values, only the size is set
    task automatic test_reset_defaults();
        logic [wbse_pkg::PIX_W-1:0] probe;

        write_reg(wbse_pkg::REG_FRAME_WIDTH, wbse_pkg::CFG_W'(3));
        write_reg(wbse_pkg::REG_FRAME_HEIGHT, wbse_pkg::CFG_W'(3));
        // a lone grey pixel above the center: gradient 18 sits on the threshold,
        // then 16 falls below it; the second frame comes from the position wrap alone
        for (int f = 0; f < 2; f++)
        begin
            probe = (f == 0) ? 12'h999 : 12'h888;
            for (int n = 0; n < 9; n++)
                send_pixel((n == 1) ? probe : wbse_pkg::BLACK, f == 0 && n == 0);
        end
        drain_pipeline();
    endtask

    // full-scale channels must average back to full scale
    task automatic test_blur_saturation();
        write_reg(wbse_pkg::REG_FILTER_MODE, wbse_pkg::CFG_W'(wbse_pkg::MODE_BLUR));
        for (int n = 0; n < 9; n++)
            send_pixel(wbse_pkg::WHITE, n == 0);
        drain_pipeline();
    endtask

    // sizes below 3 act as clamped to 3
    task automatic test_size_clamp();
        // threshold zero: every interior pixel turns white
        write_reg(wbse_pkg::REG_FILTER_MODE, wbse_pkg::CFG_W'(wbse_pkg::MODE_EDGE));
        write_reg(wbse_pkg::REG_EDGE_THRESHOLD, wbse_pkg::CFG_W'(0));
        write_reg(wbse_pkg::REG_FRAME_WIDTH, wbse_pkg::CFG_W'(1));
        write_reg(wbse_pkg::REG_FRAME_HEIGHT, wbse_pkg::CFG_W'(2));
        send_frame(3, 3, TEXTURE_RANDOM, 1'b1);
        drain_pipeline();
    endtask

    // shrink the frame while the position is past its new edge
    task automatic test_size_change_mid_frame();
        write_reg(wbse_pkg::REG_FILTER_MODE, wbse_pkg::CFG_W'($urandom_range(0, 1)));
        write_reg(wbse_pkg::REG_EDGE_THRESHOLD, wbse_pkg::CFG_W'($urandom_range(1, 30)));
        write_reg(wbse_pkg::REG_FRAME_WIDTH, wbse_pkg::CFG_W'(8));
        write_reg(wbse_pkg::REG_FRAME_HEIGHT, wbse_pkg::CFG_W'(6));
        // three rows and five pixels: the next one is row 3, column 5
        for (int n = 0; n < 29; n++)
            send_pixel(frame_pixel(TEXTURE_RANDOM), n == 0);
        drain_pipeline();
        write_reg(wbse_pkg::REG_FRAME_WIDTH, wbse_pkg::CFG_W'(4));
        write_reg(wbse_pkg::REG_FRAME_HEIGHT, wbse_pkg::CFG_W'(4));
        // out of the smaller frame: no result, column and row both wrap to 0
        send_pixel(frame_pixel(TEXTURE_RANDOM), 1'b0);
        // a whole 4x4 frame follows with no frame start
        send_frame(4, 4, TEXTURE_RANDOM, 1'b0);
        drain_pipeline();
    endtask

    // random settings, each phase a few frames of random content
    task automatic test_random_frames();
        int       sent;
        int       w;
        int       h;
        int       frames;
        int       count;
        int       roll;
        logic     start;
        texture_t tex;

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            drain_pipeline();
            no_idle = ($urandom_range(0, 3) == 0);

            write_reg(wbse_pkg::REG_FILTER_MODE, wbse_pkg::CFG_W'($urandom_range(0, 1)));
            roll = $urandom_range(0, 9);
            if (roll == 0)
                write_reg(wbse_pkg::REG_EDGE_THRESHOLD, wbse_pkg::CFG_W'(0));
            else if (roll == 1)
                write_reg(wbse_pkg::REG_EDGE_THRESHOLD, wbse_pkg::CFG_W'(127));
            else
                write_reg(wbse_pkg::REG_EDGE_THRESHOLD,
                          wbse_pkg::CFG_W'($urandom_range(1, 40)));
            for (int d = 0; d < 2; d++)
            begin
                // mostly small frames, a few below the minimum, a few a little wider
                roll = $urandom_range(0, 9);
                write_reg(d == 0 ? wbse_pkg::REG_FRAME_WIDTH : wbse_pkg::REG_FRAME_HEIGHT,
                          wbse_pkg::CFG_W'(roll == 0 ? $urandom_range(0, 2) :
                                           roll == 1 ? $urandom_range(11, 24) :
                                                       $urandom_range(3, 10)));
            end
            w = clamp_size(width_q, wbse_pkg::MAX_WIDTH_DEF);
            h = clamp_size(height_q, wbse_pkg::MAX_HEIGHT_DEF);

            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++)
            begin
                tex = texture_t'($urandom_range(0, 3));
                // some frames are cut short and the next one restarts or runs on
                count = ($urandom_range(0, 5) == 0) ? $urandom_range(1, w * h - 1) : w * h;
                for (int n = 0; n < count; n++)
                begin
                    // the first pixel after new settings always marks a frame start;
                    // later a stray frame start now and then breaks a frame
                    if (n == 0)
                        start = (f == 0) || ($urandom_range(0, 3) != 0);
                    else
                        start = ($urandom_range(0, 99) == 0);
                    send_pixel(frame_pixel(tex), start);
                end
                sent += count;
            end
        end
        drain_pipeline();
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result side: random stalls
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int stall;

        stall            = 0;
        pix_out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                pix_out_ch.ready = 1'b0;
                stall--;
            end
            else
            begin
                pix_out_ch.ready = 1'b1;
                if (!no_idle && $urandom_range(0, 4) == 0)
                    stall = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        filtered_t want;

        if (rst_n && pix_out_ch.valid && pix_out_ch.ready)
        begin
            if (expected_pixels.size() == 0)
                report_mismatch($sformatf("result with nothing expected: pixel_out %h out_last %b",
                                          pix_out_ch.pixel_out, pix_out_ch.out_last));
            else
            begin
                want = expected_pixels.pop_front();
                if (pix_out_ch.pixel_out !== want.pixel || pix_out_ch.out_last !== want.last)
                    report_mismatch($sformatf("pixel_out exp %h got %h, out_last exp %b got %b",
                                              want.pixel, pix_out_ch.pixel_out,
                                              want.last, pix_out_ch.out_last));
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: cycles in which no request moves on either channel
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watchdog
        int idle_cycles;

        if (!rst_n || (pix_in_ch.valid && pix_in_ch.ready) ||
            (pix_out_ch.valid && pix_out_ch.ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = wbse_pkg::REG_FILTER_MODE;
        cfg_data              = '0;
        pix_in_ch.valid       = 1'b0;
        pix_in_ch.pixel_in    = '0;
        pix_in_ch.frame_start = 1'b0;
        error_count           = 0;
        no_idle               = 1'b0;

        // model state as reset leaves it
        mode_q      = wbse_pkg::RST_FILTER_MODE;
        threshold_q = wbse_pkg::RST_EDGE_THRESHOLD;
        width_q     = wbse_pkg::RST_FRAME_WIDTH;
        height_q    = wbse_pkg::RST_FRAME_HEIGHT;
        foreach (line_mem[i])
            line_mem[i] = '0;
        foreach (win[i])
            win[i] = '0;
        row_pos = 0;
        col_pos = 0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_blur_saturation();
        test_size_clamp();
        test_size_change_mid_frame();
        test_random_frames();

        // extra cycles catch results nobody asked for
        repeat (4 * DRAIN_CYCLES) @(posedge clk);
        if (expected_pixels.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_pixels.size()));

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
